// ===== hw/rtl/aspa_pkg.sv =====
// ----------------------------------------------------------------------------
// aspa_pkg
// Shared types and constants of the audio source priority arbiter: field
// widths, status codes, register indexes and the controller/datapath links.
// ----------------------------------------------------------------------------
package aspa_pkg;

    localparam int ID_W    = 5;
    localparam int PRIO_W  = 8;
    localparam int STAT_W  = 3;
    localparam int MASK_W  = 16;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 2;

    // Source id that means "nobody" (no owner, nothing pending, purged slot)
    localparam logic [ID_W-1:0] NONE_ID = 5'd16;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_GRANT   = 3'd0;
    localparam logic [STAT_W-1:0] ST_PEND    = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STAT_W-1:0] ST_RELEASE = 3'd3;
    localparam logic [STAT_W-1:0] ST_PURGE   = 3'd4;

    // Action codes
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_PRIO_LO   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PRIO_HI   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PRIMARY   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_NO_RESUME = 2'd3;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_POP   = 5'b00100,
        S_PURGE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the incoming word
        logic exec;        // decide the request or release
        logic pop_step;    // check one stack entry during owner release
        logic purge_step;  // check one stack entry during non-owner release
        logic emit;        // result goes to the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_pop;
        logic need_purge;
        logic pop_last;
        logic purge_last;
    } t_dp_sts;

    // One result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   current_source;
        logic              owner_changed;
        logic              stack_overflow;
    } t_result;

endpackage

// ===== hw/rtl/aspa_ctrl.sv =====
// ----------------------------------------------------------------------------
// aspa_ctrl
// Sequencer of the arbiter: takes one word, runs the decision, walks the
// resume stack when a release needs it and hands the result to the output.
// ----------------------------------------------------------------------------
module aspa_ctrl
    import aspa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_pop) begin
                    n_state = S_POP;
                end else if (i_sts.need_purge) begin
                    n_state = S_PURGE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                o_cmd.pop_step = 1'b1;
                if (i_sts.pop_last) begin
                    n_state = S_DONE;
                end
            end
            S_PURGE: begin
                o_cmd.purge_step = 1'b1;
                if (i_sts.purge_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register has room
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/aspa_dpath.sv =====
// ----------------------------------------------------------------------------
// aspa_dpath
// Arbitration state: owner, held priority, pending source and the resume
// stack memory with its depth, plus the scan pointer used by releases.
// ----------------------------------------------------------------------------
module aspa_dpath
    import aspa_pkg::*;
#(
    parameter int NUM_SOURCES = 16,
    parameter int STACK_DEPTH = 32
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_act,
    input  logic [ID_W-1:0]        i_id,
    input  logic [2*CFG_W-1:0]     i_prio,
    input  logic [MASK_W-1:0]      i_primary,
    input  logic [MASK_W-1:0]      i_no_resume,
    output t_dp_sts                o_sts,
    output t_result                o_res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // Captured word and bookkeeping
    logic              r_act;
    logic [ID_W-1:0]   r_id;
    logic [ID_W-1:0]   r_before;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic              r_ovf;
    logic              n_ovf;

    // Arbitration state
    logic [ID_W-1:0]   r_owner;
    logic [ID_W-1:0]   n_owner;
    logic [PRIO_W-1:0] r_held;
    logic [PRIO_W-1:0] n_held;
    logic [ID_W-1:0]   r_wait;
    logic [ID_W-1:0]   n_wait;
    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     n_depth;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     n_ptr;

    // Resume stack memory
    logic [ID_W-1:0]   mem [STACK_DEPTH];
    logic [ID_W-1:0]   r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ID_W-1:0]   wr_data;

    logic              id_ok;
    logic              owner_ok;
    logic [PRIO_W-1:0] req_prio;
    logic [DW-1:0]     depth_base;
    logic [DW-1:0]     depth_m1;
    logic              pop_hit;

    assign id_ok      = (r_id < ID_W'(NUM_SOURCES));
    assign owner_ok   = (r_owner < ID_W'(NUM_SOURCES));
    assign req_prio   = i_prio[{r_id[3:0], 3'b000} +: PRIO_W];
    assign depth_base = i_primary[r_id[3:0]] ? '0 : r_depth;
    assign depth_m1   = r_depth - DW'(1);
    assign pop_hit    = (r_rd_data != NONE_ID) && (r_rd_data != r_id);

    // Decision, stack walk and memory port control
    always_comb begin
        n_status = r_status;
        n_ovf    = r_ovf;
        n_owner  = r_owner;
        n_held   = r_held;
        n_wait   = r_wait;
        n_depth  = r_depth;
        n_ptr    = r_ptr;
        rd_addr  = r_ptr;
        wr_en    = 1'b0;
        wr_addr  = r_ptr;
        wr_data  = NONE_ID;
        o_sts    = '0;

        if (i_cmd.exec) begin
            n_ovf = 1'b0;
            if (!id_ok) begin
                n_status = ST_INVALID;
            end else if (r_act == ACT_REQUEST) begin
                if (r_owner == r_id) begin
                    n_status = ST_GRANT;
                end else if (req_prio >= r_held) begin
                    n_held   = req_prio;
                    n_wait   = NONE_ID;
                    n_depth  = depth_base;
                    n_status = ST_GRANT;
                    n_owner  = r_id;
                    // Save the preempted owner for later resumption
                    if (owner_ok && !i_no_resume[r_owner[3:0]]) begin
                        if (depth_base < DW'(STACK_DEPTH)) begin
                            wr_en   = 1'b1;
                            wr_addr = depth_base[AW-1:0];
                            wr_data = r_owner;
                            n_depth = depth_base + DW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end else begin
                    n_wait   = r_id;
                    n_status = ST_PEND;
                end
            end else if (r_owner == r_id) begin
                n_held   = '0;
                n_status = ST_RELEASE;
                if (r_wait != NONE_ID && r_wait != r_id) begin
                    n_owner = r_wait;
                    n_wait  = NONE_ID;
                end else if (r_depth != '0) begin
                    // Start the search at the top of the stack
                    o_sts.need_pop = 1'b1;
                    rd_addr        = depth_m1[AW-1:0];
                    n_ptr          = depth_m1[AW-1:0];
                end
            end else begin
                n_status = ST_PURGE;
                if (r_wait == r_id) begin
                    n_wait = NONE_ID;
                end
                if (r_depth != '0) begin
                    // Start the purge at the bottom of the stack
                    o_sts.need_purge = 1'b1;
                    rd_addr          = '0;
                    n_ptr            = '0;
                end
            end
        end

        // Pop one entry: stop on a usable source or at the bottom
        if (i_cmd.pop_step) begin
            if (pop_hit) begin
                o_sts.pop_last = 1'b1;
                n_owner        = r_rd_data;
                n_depth        = DW'(r_ptr);
            end else if (r_ptr == '0) begin
                o_sts.pop_last = 1'b1;
                n_depth        = '0;
            end else begin
                n_ptr   = r_ptr - AW'(1);
                rd_addr = r_ptr - AW'(1);
            end
        end

        // Purge one entry: blank it if it holds the releasing source
        if (i_cmd.purge_step) begin
            if (r_rd_data == r_id) begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = NONE_ID;
            end
            if (DW'(r_ptr) == depth_m1) begin
                o_sts.purge_last = 1'b1;
            end else begin
                n_ptr   = r_ptr + AW'(1);
                rd_addr = r_ptr + AW'(1);
            end
        end
    end

    // Stack memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Arbitration state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= NONE_ID;
            r_held  <= '0;
            r_wait  <= NONE_ID;
            r_depth <= '0;
        end else begin
            r_owner <= n_owner;
            r_held  <= n_held;
            r_wait  <= n_wait;
            r_depth <= n_depth;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_act;
            r_id     <= i_id;
            r_before <= r_owner;
        end
        r_status <= n_status;
        r_ovf    <= n_ovf;
        r_ptr    <= n_ptr;
    end

    assign o_res.status         = r_status;
    assign o_res.current_source = r_owner;
    assign o_res.owner_changed  = (r_owner != r_before);
    assign o_res.stack_overflow = r_ovf;

endmodule

// ===== hw/rtl/audio_source_priority_arbiter_unit.sv =====
// ----------------------------------------------------------------------------
// audio_source_priority_arbiter_unit
// Grants a shared audio path to one source at a time by configured priority,
// with one pending slot and a resume stack of preempted owners.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per request or release; tuser carries the action
//   (0 request, 1 release), tdata[4:0] the source id.
//   Master stream: one result word per input word; tuser is the status,
//   tdata holds the owner after the step, owner-changed and overflow flags.
//   Configuration channel: write a register by index (0/1 priority bytes,
//   2 primary mask, 3 no-resume mask) while no word is in flight.
//   A request, an invalid id or a release that hands over to the pending
//   source goes straight from the decision step to the result. An owner
//   release that searches the stack pops it from the top until it finds a
//   usable source or the bottom; a non-owner release purges every stack
//   entry from the bottom. The stack memory read port reads one entry a cycle
//   during these walks.
//   One word is worked on at a time; the next is taken once the result sits
//   in the output register, even while the receiver stalls. A stalled result
//   holds the block in its final step until the output register frees.
//   Reset clears the owner, pending slot, held priority, stack depth and all
//   configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module audio_source_priority_arbiter_unit
    import aspa_pkg::*;
#(
    parameter int NUM_SOURCES = 16,
    parameter int STACK_DEPTH = 32
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [4:0] source_id, [7:5] zero
    input  logic              s_axis_tuser,   // [0] action
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [4:0] current_source,
                                              // [5] owner_changed,
                                              // [6] stack_overflow, [7] zero
    output logic [STAT_W-1:0] m_axis_tuser    // [2:0] status
);

    logic [CFG_W-1:0]  r_prio_lo;
    logic [CFG_W-1:0]  r_prio_hi;
    logic [MASK_W-1:0] r_primary;
    logic [MASK_W-1:0] r_no_resume;

    logic              r_m_valid;
    t_result           r_m_res;
    logic              out_free;

    t_cmd              cmd;
    t_dp_sts           dp_sts;
    t_result           dp_res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_lo   <= '0;
            r_prio_hi   <= '0;
            r_primary   <= '0;
            r_no_resume <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRIO_LO:   r_prio_lo   <= i_cfg_data;
                CFG_PRIO_HI:   r_prio_hi   <= i_cfg_data;
                CFG_PRIMARY:   r_primary   <= i_cfg_data[MASK_W-1:0];
                CFG_NO_RESUME: r_no_resume <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    aspa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_sts      (dp_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Arbitration datapath
    aspa_dpath #(
        .NUM_SOURCES (NUM_SOURCES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_act       (s_axis_tuser),
        .i_id        (s_axis_tdata[ID_W-1:0]),
        .i_prio      ({r_prio_hi, r_prio_lo}),
        .i_primary   (r_primary),
        .i_no_resume (r_no_resume),
        .o_sts       (dp_sts),
        .o_res       (dp_res)
    );

    // Output register: load a word when empty or being drained
    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_m_res <= dp_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {1'b0, r_m_res.stack_overflow, r_m_res.owner_changed,
                            r_m_res.current_source};

    // Only one word in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while another was in flight");

    // A dropped push only happens on a grant
    a_ovf_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tuser == ST_GRANT)
        else $error("stack overflow flagged without a grant");

    // Pending, rejected and purge results never move ownership
    a_no_owner_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_PEND || m_axis_tuser == ST_INVALID
                          || m_axis_tuser == ST_PURGE) |-> !m_axis_tdata[5])
        else $error("ownership changed on a non-owning step");

    // Emitting a new word never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !r_m_valid || m_axis_tready)
        else $error("result overwritten before it was taken");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio source priority arbiter. A bit-accurate
// model of owner, pending slot, held priority and resume stack predicts one
// result word per accepted input word; the scoreboard compares each result
// field by field. Directed words cover grants, pending, handover, purge and
// invalid ids. Random words follow, with preemption chains that fill the
// stack, over several register settings. Both sides stall at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top
    import aspa_pkg::*;
;

    localparam int NUM_SRC    = 16;
    localparam int STK_DEPTH  = 32;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE_CYC = 3 + STK_DEPTH + 8;

    // Arbitration model and result scoreboard
    class path_owner_model;
        logic [CFG_W-1:0]  prio_lo;
        logic [CFG_W-1:0]  prio_hi;
        logic [MASK_W-1:0] primary;
        logic [MASK_W-1:0] no_resume;
        logic [ID_W-1:0]   owner;
        logic [ID_W-1:0]   waiting;
        logic [PRIO_W-1:0] held;
        logic [ID_W-1:0]   resume_stk [STK_DEPTH];
        int                depth;
        t_result           due_results [$];
        int                mismatches;

        function new();
            prio_lo    = '0;
            prio_hi    = '0;
            primary    = '0;
            no_resume  = '0;
            owner      = NONE_ID;
            waiting    = NONE_ID;
            held       = '0;
            depth      = 0;
            mismatches = 0;
        endfunction

        function logic [PRIO_W-1:0] prio_of(logic [ID_W-1:0] src);
            int k;
            k = int'(src[2:0]);
            return src[3] ? prio_hi[8*k +: 8] : prio_lo[8*k +: 8];
        endfunction

        function void configure(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PRIO_LO:   prio_lo   = data;
                CFG_PRIO_HI:   prio_hi   = data;
                CFG_PRIMARY:   primary   = data[MASK_W-1:0];
                CFG_NO_RESUME: no_resume = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted word and queue its result
        function void note_word(logic act, logic [ID_W-1:0] id);
            t_result         res;
            logic [ID_W-1:0] prev;
            logic [ID_W-1:0] ent;
            prev = owner;
            res.stack_overflow = 1'b0;
            if (id >= NUM_SRC) begin
                res.status = ST_INVALID;
            end else if (act == ACT_REQUEST) begin
                if (owner == id) begin
                    res.status = ST_GRANT;
                end else if (prio_of(id) >= held) begin
                    held    = prio_of(id);
                    waiting = NONE_ID;
                    if (primary[id[3:0]])
                        depth = 0;
                    // save the preempted owner for later resumption
                    if (owner < NUM_SRC && !no_resume[owner[3:0]]) begin
                        if (depth < STK_DEPTH) begin
                            resume_stk[depth] = owner;
                            depth++;
                        end else begin
                            res.stack_overflow = 1'b1;
                        end
                    end
                    owner      = id;
                    res.status = ST_GRANT;
                end else begin
                    waiting    = id;
                    res.status = ST_PEND;
                end
            end else if (owner == id) begin
                // hand over to the pending source, else search the stack
                if (waiting != NONE_ID && waiting != id) begin
                    owner   = waiting;
                    waiting = NONE_ID;
                end else begin
                    while (depth > 0) begin
                        depth--;
                        ent = resume_stk[depth];
                        if (ent != NONE_ID && ent != id) begin
                            owner = ent;
                            break;
                        end
                    end
                end
                held       = '0;
                res.status = ST_RELEASE;
            end else begin
                if (waiting == id)
                    waiting = NONE_ID;
                for (int i = 0; i < depth; i++) begin
                    if (resume_stk[i] == id)
                        resume_stk[i] = NONE_ID;
                end
                res.status = ST_PURGE;
            end
            res.current_source = owner;
            res.owner_changed  = (owner != prev);
            due_results.push_back(res);
        endfunction

        // Compare one result word with the oldest expectation
        function void check_word(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result word with nothing expected: status %0d source %0d",
                       got.status, got.current_source);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.current_source !== want.current_source) begin
                $error("current_source: expected %0d, got %0d",
                       want.current_source, got.current_source);
                mismatches++;
            end
            if (got.owner_changed !== want.owner_changed) begin
                $error("owner_changed: expected %0d, got %0d",
                       want.owner_changed, got.owner_changed);
                mismatches++;
            end
            if (got.stack_overflow !== want.stack_overflow) begin
                $error("stack_overflow: expected %0d, got %0d",
                       want.stack_overflow, got.stack_overflow);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;

    path_owner_model model;
    int              cycle_count = 0;
    int              chain_left  = 0;
    bit              hold_req    = 1'b0;
    bit              calm        = 1'b0;

    audio_source_priority_arbiter_unit #(
        .NUM_SOURCES (NUM_SRC),
        .STACK_DEPTH (STK_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up after a generous number of cycles
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Check every result word taken by the receiver
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = m_axis_tuser;
            got.current_source = m_axis_tdata[4:0];
            got.owner_changed  = m_axis_tdata[5];
            got.stack_overflow = m_axis_tdata[6];
            model.check_word(got);
        end
    end

    // Receiver: random stalls, one long hold-off, none in the calm tail
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !calm) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int n = 1; n < HOLD_LEN; n++)
                    @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    end

    // Write one register; returns at the accepting edge
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.configure(idx, data);
    endtask

    task automatic set_config(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                              logic [MASK_W-1:0] pri, logic [MASK_W-1:0] nores);
        write_reg(CFG_PRIO_LO, lo);
        write_reg(CFG_PRIO_HI, hi);
        write_reg(CFG_PRIMARY, {{(CFG_W-MASK_W){1'b0}}, pri});
        write_reg(CFG_NO_RESUME, {{(CFG_W-MASK_W){1'b0}}, nores});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one word and wait for it to be taken; returns at the accepting edge
    task automatic send_word(logic act, logic [ID_W-1:0] id);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, id};
        do @(posedge i_clk); while (!s_axis_tready);
        model.note_word(act, id);
        // now and then a random gap before the next word
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
    endtask

    // Drop valid, let every result arrive, then let the block settle
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (model.due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Pick the next random word from the model's view of the arbiter
    function automatic void pick_word(output logic act, output logic [ID_W-1:0] id);
        int kind;
        logic [ID_W-1:0] any_src;
        any_src = ID_W'($urandom_range(0, NUM_SRC - 1));
        if (chain_left == 0 && $urandom_range(0, 99) < 3)
            chain_left = $urandom_range(20, 45);
        // preemption chain: requests from sources other than the owner
        if (chain_left > 0) begin
            chain_left--;
            act = ACT_REQUEST;
            id  = (any_src == model.owner) ? ID_W'((any_src + 1) % NUM_SRC) : any_src;
            return;
        end
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            act = $urandom_range(0, 1) ? ACT_RELEASE : ACT_REQUEST;
            id  = ID_W'($urandom_range(NUM_SRC, 31));
        end else if (kind < 50) begin
            act = ACT_REQUEST;
            id  = any_src;
        end else if (kind < 68) begin
            act = ACT_RELEASE;
            id  = (model.owner < NUM_SRC) ? model.owner : any_src;
        end else if (kind < 80) begin
            act = ACT_RELEASE;
            id  = (model.waiting < NUM_SRC) ? model.waiting : any_src;
        end else if (kind < 92) begin
            act = ACT_RELEASE;
            id  = any_src;
        end else begin
            act = ACT_REQUEST;
            id  = (model.owner < NUM_SRC) ? model.owner : any_src;
        end
    endfunction

    task automatic run_random(int count);
        logic            act;
        logic [ID_W-1:0] id;
        for (int n = 0; n < count; n++) begin
            pick_word(act, id);
            send_word(act, id);
        end
    endtask

    // Main sequence
    initial begin
        model         = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_REQUEST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Source k has priority 16k; 15 is primary, 3 is never resumed
        set_config(64'h7060_5040_3020_1000, 64'hF0E0_D0C0_B0A0_9080,
                   16'h8000, 16'h0008);
        send_word(ACT_REQUEST, 5'd2);
        send_word(ACT_REQUEST, 5'd2);     // owner asks again
        send_word(ACT_REQUEST, 5'd1);     // lower priority: pending
        send_word(ACT_RELEASE, 5'd2);     // hand over to the pending source
        send_word(ACT_REQUEST, 5'd4);
        send_word(ACT_REQUEST, 5'd3);
        send_word(ACT_REQUEST, 5'd5);     // winner clears the pending slot
        send_word(ACT_REQUEST, 5'd3);
        send_word(ACT_RELEASE, 5'd3);     // purge from the pending slot
        send_word(ACT_RELEASE, 5'd4);     // purge from the stack
        send_word(ACT_RELEASE, 5'd5);     // skip a purged entry while popping
        send_word(ACT_RELEASE, 5'd1);     // nothing to hand over
        send_word(ACT_REQUEST, 5'd31);
        send_word(ACT_REQUEST, 5'd16);
        send_word(ACT_RELEASE, 5'd17);
        send_word(ACT_REQUEST, 5'd15);    // primary source empties the stack
        send_word(ACT_REQUEST, 5'd3);
        send_word(ACT_RELEASE, 5'd15);
        send_word(ACT_REQUEST, 5'd0);     // no-resume owner is not pushed
        send_word(ACT_RELEASE, 5'd0);
        send_word(ACT_REQUEST, 5'd14);
        send_word(ACT_RELEASE, 5'd14);
        run_random(150);
        drain();

        // All priorities equal at zero: deep stacks and overflow
        set_config('0, '0, '0, '0);
        run_random(120);
        hold_req = 1'b1;
        run_random(130);
        drain();

        // Every source primary and never resumed, top priorities
        set_config('1, '1, 16'hFFFF, 16'hFFFF);
        run_random(200);
        drain();

        set_config({$urandom, $urandom}, {$urandom, $urandom},
                   MASK_W'($urandom), MASK_W'($urandom));
        run_random(220);
        drain();

        // Many ties between a few priority levels, sparse masks
        begin
            logic [CFG_W-1:0] lo;
            logic [CFG_W-1:0] hi;
            for (int k = 0; k < 8; k++) begin
                lo[8*k +: 8] = PRIO_W'($urandom_range(0, 2));
                hi[8*k +: 8] = PRIO_W'($urandom_range(0, 2));
            end
            set_config(lo, hi, MASK_W'($urandom & $urandom),
                       MASK_W'($urandom & $urandom));
        end
        run_random(220);
        drain();

        set_config({$urandom, $urandom}, {$urandom, $urandom}, '0,
                   MASK_W'($urandom));
        run_random(220);
        drain();

        // Equal top priorities, masks clear; calm tail at the end
        set_config('1, '1, '0, '0);
        run_random(70);
        calm = 1'b1;
        run_random(150);
        drain();

        if (model.mismatches == 0 && model.due_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
